// ===== src/rnsq_pkg.sv =====
// Shared constants, row word type and back-end state type for the
// row-normalized squared error sum block. No dependencies.
`default_nettype none

package rnsq_pkg;

  // Field and accumulator widths
  localparam int MAX_COLUMNS = 1024;
  localparam int VAL_W       = 32;   // Q16.16 input values
  localparam int W_W         = 16;   // Q8.8 weight
  localparam int COL_W       = 11;   // column count register
  localparam int POS_W       = 10;   // column position
  localparam int SUM_W       = 48;   // row reference sum
  localparam int SQ_W        = 64;   // row square sum, total
  localparam int PROD_W      = 80;   // weighted square before scaling
  localparam int C2_W        = 21;   // column count squared
  localparam int DEN_W       = 95;   // reference sum squared
  localparam int NUM_W       = 84;   // square sum times column count squared
  localparam int MUL_STEPS   = 5;    // partial products per row
  localparam int DIV_STEPS   = 64;   // quotient bits per row
  localparam int FIFO_DEPTH  = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTING    = 1'd1;

  // One closed row, handed from the front end to the back end
  typedef struct packed {
    logic [SQ_W-1:0]  sq_sum;
    logic [SUM_W-1:0] ref_sum;   // two's complement
    logic [COL_W-1:0] cols;      // clamped column count, 1..MAX_COLUMNS
    logic             last;
    logic             sat;       // saturation seen in this row
  } row_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CMP,
    B_DIV,
    B_ADD,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/rnsq_front.sv =====
// Front end: accepts elements, forms weighted squared errors in a short
// pipeline and accumulates rows. Depends on rnsq_pkg.
`default_nettype none

module rnsq_front
  import rnsq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [VAL_W-1:0] in_reference_value,
  input  logic signed [VAL_W-1:0] in_simulated_value,
  input  logic [W_W-1:0]          in_weight_value,
  input  logic                    in_last_element,
  input  logic [COL_W-1:0]        column_count,
  input  logic                    weighting_enabled,
  input  logic                    q_full,
  output logic                    q_push,
  output row_entry_t              q_entry
);

  // Pipeline registers
  logic              a_vld_r, b_vld_r, c_vld_r;
  logic [VAL_W-1:0]  a_ref_r, b_ref_r, c_ref_r;
  logic [VAL_W-1:0]  a_dmag_r;
  logic [SQ_W-1:0]   b_sq_r;
  logic [PROD_W-1:0] c_prod_r;
  logic [W_W-1:0]    a_w_r, b_w_r;
  logic              a_last_r, b_last_r, c_last_r;

  // Row accumulators
  logic [POS_W-1:0]  pos_r;
  logic [SQ_W-1:0]   sq_sum_r;
  logic [SUM_W-1:0]  ref_sum_r;
  logic              sat_row_r;

  logic              en;
  logic [VAL_W:0]    diff;
  logic [VAL_W:0]    diff_neg;
  logic [VAL_W-1:0]  dmag;
  logic [COL_W-1:0]  cc_eff;
  logic [COL_W-1:0]  pos_inc;
  logic              close_row;
  logic              term_sat;
  logic [SQ_W-1:0]   term;
  logic [SQ_W:0]     sq_add;
  logic              sq_sat;
  logic [SQ_W-1:0]   sq_new;
  logic [SUM_W:0]    ref_add;
  logic              ref_sat;
  logic [SUM_W-1:0]  ref_new;
  logic              sat_any;

  // Difference magnitude; fits VAL_W bits unsigned
  always_comb begin
    diff     = {in_reference_value[VAL_W-1], in_reference_value}
             - {in_simulated_value[VAL_W-1], in_simulated_value};
    diff_neg = (VAL_W+1)'(0) - diff;
    dmag     = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
  end

  // Row end detection with clamped column count
  always_comb begin
    if (column_count == '0) begin
      cc_eff = COL_W'(1);
    end else if (column_count > COL_W'(MAX_COLUMNS)) begin
      cc_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cc_eff = column_count;
    end
    pos_inc   = {1'b0, pos_r} + COL_W'(1);
    close_row = (pos_inc >= cc_eff) || c_last_r;
  end

  // Saturating accumulation of the element at the last stage
  always_comb begin
    term_sat = |c_prod_r[PROD_W-1:SQ_W+8];
    term     = term_sat ? '1 : c_prod_r[SQ_W+7:8];
    sq_add   = {1'b0, sq_sum_r} + {1'b0, term};
    sq_sat   = sq_add[SQ_W];
    sq_new   = sq_sat ? '1 : sq_add[SQ_W-1:0];
    ref_add  = {ref_sum_r[SUM_W-1], ref_sum_r}
             + {{(SUM_W+1-VAL_W){c_ref_r[VAL_W-1]}}, c_ref_r};
    ref_sat  = ref_add[SUM_W] ^ ref_add[SUM_W-1];
    if (!ref_sat) begin
      ref_new = ref_add[SUM_W-1:0];
    end else if (ref_add[SUM_W]) begin
      ref_new = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      ref_new = {1'b0, {(SUM_W-1){1'b1}}};
    end
    sat_any = sat_row_r | term_sat | sq_sat | ref_sat;
  end

  // Stall everything while a closing row cannot enter the queue
  assign en      = !(c_vld_r && close_row && q_full);
  assign in_full = !en;
  assign q_push  = c_vld_r && close_row && !q_full;

  always_comb begin
    q_entry.sq_sum  = sq_new;
    q_entry.ref_sum = ref_new;
    q_entry.cols    = cc_eff;
    q_entry.last    = c_last_r;
    q_entry.sat     = sat_any;
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_push;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ref_r  <= in_reference_value;
      a_dmag_r <= dmag;
      a_w_r    <= weighting_enabled ? in_weight_value : W_W'(256);
      a_last_r <= in_last_element;
      b_ref_r  <= a_ref_r;
      b_sq_r   <= a_dmag_r * a_dmag_r;
      b_w_r    <= a_w_r;
      b_last_r <= a_last_r;
      c_ref_r  <= b_ref_r;
      c_prod_r <= b_sq_r * b_w_r;
      c_last_r <= b_last_r;
    end
  end

  // Accumulate the row, clear on close
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      sq_sum_r  <= '0;
      ref_sum_r <= '0;
      sat_row_r <= 1'b0;
    end else if (en && c_vld_r) begin
      if (close_row) begin
        pos_r     <= '0;
        sq_sum_r  <= '0;
        ref_sum_r <= '0;
        sat_row_r <= 1'b0;
      end else begin
        pos_r     <= pos_inc[POS_W-1:0];
        sq_sum_r  <= sq_new;
        ref_sum_r <= ref_new;
        sat_row_r <= sat_any;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rnsq_row_fifo.sv =====
// Short queue of closed rows between front and back end.
// Depends on rnsq_pkg for the row word type and depth.
`default_nettype none

module rnsq_row_fifo
  import rnsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  row_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output row_entry_t head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  row_entry_t       slots_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rnsq_back.sv =====
// Back end: per row forms S*c^2 and R^2 with a shared 32x32 multiplier,
// divides bit-serially, adds to the running total and holds the result.
// Depends on rnsq_pkg.
`default_nettype none

module rnsq_back
  import rnsq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  row_entry_t      q_head,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [SQ_W-1:0] out_total_cost,
  output logic            out_zero_mean_seen,
  output logic            out_saturated
);

  localparam int MSTEP_W = $clog2(MUL_STEPS + 1);
  localparam int CNT_W   = $clog2(DIV_STEPS);

  back_state_t        state_r, state_nxt;

  logic [SQ_W-1:0]    s_r;
  logic [SUM_W-1:0]   mag_r;
  logic [C2_W-1:0]    c2_r;
  logic               last_r;
  logic [MSTEP_W-1:0] mstep_r;
  logic [SQ_W-1:0]    prod_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   rem_r;
  logic [SQ_W-1:0]    qlo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQ_W-1:0]    total_r;
  logic [1:0]         flags_r;   // bit 0 zero mean, bit 1 saturated
  logic               out_vld_r;
  logic [SQ_W-1:0]    out_total_r;
  logic [1:0]         out_flags_r;

  logic               head_zero;
  logic [SUM_W-1:0]   head_mag;
  logic [2*COL_W-1:0] head_c2;
  logic [31:0]        mul_a, mul_b;
  logic [DEN_W-1:0]   den_add;
  logic [NUM_W-1:0]   num_add;
  logic               quot_ovf;
  logic [DEN_W:0]     trial;
  logic               trial_ge;
  logic [DEN_W:0]     trial_sub;
  logic [SQ_W:0]      total_add;
  logic               mul_done;
  logic               div_done;

  logic               ld_row, do_mul, do_cmp, do_div, do_add, do_emit;

  // Decode the queue head
  always_comb begin
    head_zero = (q_head.ref_sum == '0);
    head_mag  = q_head.ref_sum[SUM_W-1] ? (SUM_W'(0) - q_head.ref_sum) : q_head.ref_sum;
    head_c2   = {COL_W'(0), q_head.cols} * {COL_W'(0), q_head.cols};
  end

  // Select partial product operands
  always_comb begin
    case (mstep_r)
      MSTEP_W'(0): begin
        mul_a = mag_r[31:0];
        mul_b = mag_r[31:0];
      end
      MSTEP_W'(1): begin
        mul_a = mag_r[31:0];
        mul_b = 32'(mag_r[SUM_W-1:32]);
      end
      MSTEP_W'(2): begin
        mul_a = 32'(mag_r[SUM_W-1:32]);
        mul_b = 32'(mag_r[SUM_W-1:32]);
      end
      MSTEP_W'(3): begin
        mul_a = s_r[31:0];
        mul_b = 32'(c2_r);
      end
      MSTEP_W'(4): begin
        mul_a = s_r[SQ_W-1:32];
        mul_b = 32'(c2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Place the product of the previous step
  always_comb begin
    den_add = '0;
    num_add = '0;
    case (mstep_r)
      MSTEP_W'(1): den_add = DEN_W'(prod_r);
      MSTEP_W'(2): den_add = DEN_W'(prod_r) << 33;
      MSTEP_W'(3): den_add = DEN_W'(prod_r) << 64;
      MSTEP_W'(4): num_add = NUM_W'(prod_r);
      MSTEP_W'(5): num_add = NUM_W'(prod_r) << 32;
      default: begin
        den_add = '0;
        num_add = '0;
      end
    endcase
  end

  // Overflow check, one restoring division step, total add
  always_comb begin
    quot_ovf  = DEN_W'(num_r[NUM_W-1:32]) >= den_r;
    trial     = {rem_r, qlo_r[SQ_W-1]};
    trial_ge  = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
    total_add = {1'b0, total_r} + {1'b0, qlo_r};
    mul_done  = (mstep_r == MSTEP_W'(MUL_STEPS));
    div_done  = (cnt_r == CNT_W'(DIV_STEPS - 1));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head_zero) begin
            state_nxt = q_head.last ? B_EMIT : B_IDLE;
          end else begin
            state_nxt = B_MUL;
          end
        end
      end
      B_MUL: begin
        if (mul_done) begin
          state_nxt = B_CMP;
        end
      end
      B_CMP: begin
        if (quot_ovf) begin
          state_nxt = last_r ? B_EMIT : B_IDLE;
        end else begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        state_nxt = last_r ? B_EMIT : B_IDLE;
      end
      B_EMIT: begin
        if (!out_vld_r) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Strobes per state
  always_comb begin
    ld_row  = 1'b0;
    do_mul  = 1'b0;
    do_cmp  = 1'b0;
    do_div  = 1'b0;
    do_add  = 1'b0;
    do_emit = 1'b0;
    case (state_r)
      B_IDLE:  ld_row  = !q_empty;
      B_MUL:   do_mul  = 1'b1;
      B_CMP:   do_cmp  = 1'b1;
      B_DIV:   do_div  = 1'b1;
      B_ADD:   do_add  = 1'b1;
      B_EMIT:  do_emit = !out_vld_r;
      default: ld_row  = 1'b0;
    endcase
  end

  assign q_pop              = ld_row;
  assign out_empty          = !out_vld_r;
  assign out_total_cost     = out_total_r;
  assign out_zero_mean_seen = out_flags_r[0];
  assign out_saturated      = out_flags_r[1];

  // Control state, total and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      total_r   <= '0;
      flags_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_pop && out_vld_r) begin
        out_vld_r <= 1'b0;
      end
      if (ld_row) begin
        flags_r[1] <= flags_r[1] | q_head.sat;
        if (head_zero) begin
          total_r    <= '1;
          flags_r[0] <= 1'b1;
        end
      end
      if (do_cmp && quot_ovf) begin
        total_r    <= '1;
        flags_r[1] <= 1'b1;
      end
      if (do_add) begin
        if (total_add[SQ_W]) begin
          total_r    <= '1;
          flags_r[1] <= 1'b1;
        end else begin
          total_r <= total_add[SQ_W-1:0];
        end
      end
      if (do_emit) begin
        out_vld_r <= 1'b1;
        total_r   <= '0;
        flags_r   <= '0;
      end
    end
  end

  // Row datapath: load, multiply steps, divide steps
  always_ff @(posedge clk) begin
    if (ld_row) begin
      s_r     <= q_head.sq_sum;
      mag_r   <= head_mag;
      c2_r    <= head_c2[C2_W-1:0];
      last_r  <= q_head.last;
      mstep_r <= '0;
      den_r   <= '0;
      num_r   <= '0;
    end
    if (do_mul) begin
      prod_r  <= mul_a * mul_b;
      den_r   <= den_r + den_add;
      num_r   <= num_r + num_add;
      mstep_r <= mstep_r + MSTEP_W'(1);
    end
    if (do_cmp) begin
      rem_r <= DEN_W'(num_r[NUM_W-1:32]);
      qlo_r <= {num_r[31:0], 32'd0};
      cnt_r <= '0;
    end
    if (do_div) begin
      rem_r <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      qlo_r <= {qlo_r[SQ_W-2:0], trial_ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (do_emit) begin
      out_total_r <= total_r;
      out_flags_r <= flags_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/row_normalized_sq_error_sum.sv =====
// Row-normalized weighted squared error sum, top level.
// An element passes pipeline registers a, b and c before its row can close into the row queue.
// Elements are taken one per cycle within a row while the row queue is not full; the back end
// takes one row at a time through its multiply, compare, divide and add steps before the next.
// The result of a row marked last is registered in the emit state, which waits until the previous result is popped.
// Reset: synchronous, active low; clears all sums, the total and flags,
// column count to 1, weighting off.
`default_nettype none

module row_normalized_sq_error_sum
  import rnsq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [VAL_W-1:0] in_reference_value,
  input  logic signed [VAL_W-1:0] in_simulated_value,
  input  logic [W_W-1:0]          in_weight_value,
  input  logic                    in_last_element,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [SQ_W-1:0]         out_total_cost,
  output logic                    out_zero_mean_seen,
  output logic                    out_saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  logic [COL_W-1:0] column_count_r;
  logic             weighting_r;
  logic             q_push, q_full, q_pop, q_empty;
  row_entry_t       q_wr_entry, q_head;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COL_W'(1);
      weighting_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMN_COUNT: column_count_r <= cfg_data[COL_W-1:0];
        CFG_WEIGHTING:    weighting_r    <= cfg_data[0];
        default:          weighting_r    <= weighting_r;
      endcase
    end
  end

  rnsq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_reference_value (in_reference_value),
    .in_simulated_value (in_simulated_value),
    .in_weight_value    (in_weight_value),
    .in_last_element    (in_last_element),
    .column_count       (column_count_r),
    .weighting_enabled  (weighting_r),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_entry            (q_wr_entry)
  );

  rnsq_row_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  rnsq_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_total_cost     (out_total_cost),
    .out_zero_mean_seen (out_zero_mean_seen),
    .out_saturated      (out_saturated)
  );

endmodule

`default_nettype wire
